/* rtl/mjdcal_pkg.sv */
// Package for the MJD to calendar date converter: widths, constants, tables and types.
package mjdcal_pkg;

  localparam int unsigned DAY_BITS_DEF = 20;

  // Result field widths
  localparam int unsigned YEAR_W   = 13;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned OUT_DATA_W = 72;

  // Day offset within a year counted from March (b - floor(365.25 c)), and month code
  localparam int unsigned BD_W = 9;
  localparam int unsigned E_W  = 4;
  localparam int unsigned MON_W = 4;

  // Meeus constants as exact integers
  localparam int unsigned X1_OFFSET   = 2131139;  // 4*2400001 - 7468865
  localparam int unsigned B_OFFSET    = 2401526;  // 2400001 + 1 + 1524
  localparam int unsigned DIV_ALPHA   = 146097;
  localparam int unsigned X2_SCALE    = 20;
  localparam int unsigned X2_SUB      = 2442;
  localparam int unsigned DIV_C       = 7305;
  localparam int unsigned DD_SCALE    = 1461;
  localparam int unsigned E_NUM       = 10000;
  localparam int unsigned E_DEN       = 306001;
  localparam int unsigned YEAR_BASE_LATE  = 4716;
  localparam int unsigned YEAR_BASE_EARLY = 4715;
  localparam int unsigned DIV_CENT    = 100;
  localparam int unsigned MONTH_MAR   = 3;
  localparam int unsigned E_WRAP      = 14;

  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned SEC_PER_MIN   = 60;

  // ceil(30.6001 k): e >= k exactly when bd reaches this value
  localparam logic [BD_W-1:0] E_CEIL [17] = '{
    9'd0,   9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
    9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460, 9'd490
  };

  // floor(30.6001 e)
  localparam logic [BD_W-1:0] E_FLOOR [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  // Cumulative days before each month of a common year; upper entries unused
  localparam logic [DOY_W-1:0] DAYS_BEFORE [16] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181, 9'd212,
    9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0,   9'd0
  };

  // Time-of-day split; sec_frac carries the running remainder until the seconds step
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  sec_whole;
    logic [FRAC_W-1:0] sec_frac;
  } tod_t;

endpackage

/* rtl/mjd_to_calendar_date.sv */
// MJD to calendar date converter: twelve-stage pipeline from MJD to year, day of year and time.
//
// Usage
//   in_*  : stream slave. in_tdata carries the MJD whole day and the 32-bit day fraction.
//           A word is taken at each rising edge with in_tvalid and in_tready high.
//   out_* : stream master. out_tdata carries year, day of year, hour, minute, whole seconds
//           and the 32-bit second fraction, one result word per input word, in order.
// Result path: a word moves through stage registers 0 to 11 in order, and out_tvalid is
//   the valid bit of stage 11, where the result can be taken.
// Throughput: one word per cycle while out_tready is high; each pipeline stage holds one
//   word and a valid bit, and the constant divisions are reciprocal multiplies followed
//   by a one-step correction in the next stage, so no stage iterates.
// Stall: when out_tready is low the last stage holds its word; earlier stages keep
//   advancing into empty slots, so bubbles are squeezed out before in_tready drops.
//   Nothing is lost or repeated across a stall.
// Reset: synchronous, active low rst_n clears all valid bits; payload registers are
//   left as they are. The block has no configuration and no stored state between words.
// Years beyond 13 bits (only reachable with DAY_BITS above 20) wrap to their low 13 bits.
module mjd_to_calendar_date
  import mjdcal_pkg::*;
#(
  parameter int unsigned DAY_BITS = DAY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata, low bit up: mjd_day[DAY_BITS], day_fraction[32], zero padding
  input  logic [((DAY_BITS + 32 + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata, low bit up: year[13], day_of_year[9], hour[5], minute[6],
  //   second_whole[6], second_fraction[32], one zero pad bit
  output logic [OUT_DATA_W-1:0]                out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  localparam int unsigned NSTG = 12;

  // Value ranges and derived widths
  localparam int unsigned DAY_MAX   = (2 ** DAY_BITS) - 1;
  localparam int unsigned X1_MAX    = 4 * DAY_MAX + X1_OFFSET;
  localparam int unsigned X1W       = $clog2(X1_MAX + 1);
  localparam int unsigned ALPHA_MAX = X1_MAX / DIV_ALPHA;
  localparam int unsigned AW        = $clog2(ALPHA_MAX + 1);
  localparam int unsigned M1        = (2 ** X1W) / DIV_ALPHA;
  localparam int unsigned M1W       = $clog2(M1 + 1);
  localparam int unsigned B_MAX     = DAY_MAX + B_OFFSET + ALPHA_MAX;
  localparam int unsigned BW        = $clog2(B_MAX + 1);
  localparam int unsigned X2_MAX    = X2_SCALE * B_MAX - X2_SUB;
  localparam int unsigned X2W       = $clog2(X2_MAX + 1);
  localparam int unsigned C_MAX     = X2_MAX / DIV_C;
  localparam int unsigned CW        = $clog2(C_MAX + 1);
  localparam int unsigned M2        = (2 ** X2W) / DIV_C;
  localparam int unsigned M2W       = $clog2(M2 + 1);
  localparam int unsigned DDW       = CW + 11;
  localparam int unsigned MW        = (DDW > BW) ? DDW : BW;
  localparam int unsigned EK        = BD_W + 4;
  localparam int unsigned M3        = (E_NUM * (2 ** EK)) / E_DEN;
  localparam int unsigned M3W       = $clog2(M3 + 1);
  localparam int unsigned YFW       = (CW > YEAR_W) ? CW : YEAR_W;
  localparam int unsigned M4        = (2 ** YFW) / DIV_CENT;
  localparam int unsigned M4W       = $clog2(M4 + 1);

  // Handshake chain: a stage loads when it is empty or its successor loads
  logic [NSTG:0]   adv;
  logic [NSTG-1:0] vld_r, vld_nxt;

  always_comb begin
    adv[NSTG] = out_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt = vld_r;
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = (i == 0) ? in_tvalid : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NSTG-1];

  // Input fields
  logic [DAY_BITS-1:0] mjd_day;
  logic [FRAC_W-1:0]   day_fraction;
  assign mjd_day      = in_tdata[DAY_BITS-1:0];
  assign day_fraction = in_tdata[DAY_BITS +: FRAC_W];

  // Time-of-day path: hours, minutes, seconds in the first three stages, then carried
  tod_t tod_r [NSTG];
  tod_t tod_nxt [NSTG];
  logic [FRAC_W+HOUR_W-1:0] hour_prod;
  logic [FRAC_W+MIN_W-1:0]  min_prod;
  logic [FRAC_W+SEC_W-1:0]  sec_prod;

  always_comb begin
    hour_prod = (FRAC_W + HOUR_W)'(day_fraction) * (FRAC_W + HOUR_W)'(HOURS_PER_DAY);
    min_prod  = (FRAC_W + MIN_W)'(tod_r[0].sec_frac) * (FRAC_W + MIN_W)'(MIN_PER_HOUR);
    sec_prod  = (FRAC_W + SEC_W)'(tod_r[1].sec_frac) * (FRAC_W + SEC_W)'(SEC_PER_MIN);

    tod_nxt[0]           = '0;
    tod_nxt[0].hour      = hour_prod[FRAC_W +: HOUR_W];
    tod_nxt[0].sec_frac  = hour_prod[FRAC_W-1:0];

    tod_nxt[1]           = tod_r[0];
    tod_nxt[1].minute    = min_prod[FRAC_W +: MIN_W];
    tod_nxt[1].sec_frac  = min_prod[FRAC_W-1:0];

    tod_nxt[2]           = tod_r[1];
    tod_nxt[2].sec_whole = sec_prod[FRAC_W +: SEC_W];
    tod_nxt[2].sec_frac  = sec_prod[FRAC_W-1:0];

    for (int i = 3; i < NSTG; i++) begin
      tod_nxt[i] = tod_r[i-1];
    end
  end

  // Date path registers, named by stage
  logic [DAY_BITS-1:0] d0_r, d1_r, d2_r;
  logic [X1W-1:0]      x1_0_r, x1_1_r;
  logic [AW-1:0]       aest1_r, alpha2_r;
  logic [BW-1:0]       b3_r, b4_r, b5_r;
  logic [X2W-1:0]      x2_3_r, x2_4_r;
  logic [CW-1:0]       cest4_r, c5_r, c6_r, c7_r, c8_r;
  logic [BD_W-1:0]     bd6_r, bd7_r;
  logic [E_W-1:0]      eest7_r, e8_r;
  logic [BD_W-1:0]     day8_r;
  logic [YFW-1:0]      yf9_r, yf10_r;
  logic [DOY_W-1:0]    doy9_r, doy10_r, doy11_r;
  logic                late9_r, late10_r;
  logic [YFW-1:0]      cest10_r;
  logic [YEAR_W-1:0]   year11_r;

  logic [X1W-1:0]      x1_nxt;
  logic [X1W+M1W-1:0]  aprod;
  logic [AW-1:0]       aest_nxt;
  logic [X1W-1:0]      arem;
  logic [AW-1:0]       alpha_nxt;
  logic [BW-1:0]       b_nxt;
  logic [X2W-1:0]      x2_nxt;
  logic [X2W+M2W-1:0]  cprod;
  logic [CW-1:0]       cest_nxt;
  logic [X2W-1:0]      crem;
  logic [CW-1:0]       c_nxt;
  logic [MW-1:0]       dd_prod;
  logic [MW-1:0]       bd_full;
  logic [BD_W-1:0]     bd_nxt;
  logic [BD_W+M3W-1:0] eprod;
  logic [E_W-1:0]      eest_nxt;
  logic [E_W:0]        e_up;
  logic [E_W-1:0]      e_nxt;
  logic [BD_W-1:0]     day_nxt;
  logic [MON_W-1:0]    month;
  logic [MON_W-1:0]    month_idx;
  logic                late_nxt;
  logic [YFW-1:0]      yf_nxt;
  logic [DOY_W-1:0]    doy_nxt;
  logic [YFW+M4W-1:0]  yprod;
  logic [YFW-1:0]      yest_nxt;
  logic [YFW-1:0]      yrem;
  logic                ycarry;
  logic [YFW-1:0]      cent;
  logic                cent_zero;
  logic                leap;
  logic [DOY_W-1:0]    doy_fin;

  always_comb begin
    // Stage 0: 4z - 7468865 with z = mjd_day + 2400001
    x1_nxt = (X1W'(mjd_day) << 2) + X1W'(X1_OFFSET);

    // Stage 1: alpha estimate, low by at most one
    aprod    = (X1W + M1W)'(x1_0_r) * (X1W + M1W)'(M1);
    aest_nxt = aprod[X1W +: AW];

    // Stage 2: correct alpha
    arem      = x1_1_r - X1W'(aest1_r) * X1W'(DIV_ALPHA);
    alpha_nxt = (arem >= X1W'(DIV_ALPHA)) ? aest1_r + AW'(1) : aest1_r;

    // Stage 3: b = z + 1 + alpha - alpha/4 + 1524, then 20 b - 2442
    b_nxt  = BW'(d2_r) + BW'(B_OFFSET) + BW'(alpha2_r) - BW'(alpha2_r >> 2);
    x2_nxt = X2W'(b_nxt) * X2W'(X2_SCALE) - X2W'(X2_SUB);

    // Stage 4: c estimate
    cprod    = (X2W + M2W)'(x2_3_r) * (X2W + M2W)'(M2);
    cest_nxt = cprod[X2W +: CW];

    // Stage 5: correct c
    crem  = x2_4_r - X2W'(cest4_r) * X2W'(DIV_C);
    c_nxt = (crem >= X2W'(DIV_C)) ? cest4_r + CW'(1) : cest4_r;

    // Stage 6: bd = b - floor(365.25 c), always below 490
    dd_prod = MW'(c5_r) * MW'(DD_SCALE);
    bd_full = MW'(b5_r) - (dd_prod >> 2);
    bd_nxt  = bd_full[BD_W-1:0];

    // Stage 7: e estimate from floor(bd / 30.6001)
    eprod    = (BD_W + M3W)'(bd6_r) * (BD_W + M3W)'(M3);
    eest_nxt = eprod[EK +: E_W];

    // Stage 8: correct e, take day of month
    e_up    = (E_W + 1)'(eest7_r) + (E_W + 1)'(1);
    e_nxt   = (bd7_r >= E_CEIL[e_up]) ? eest7_r + E_W'(1) : eest7_r;
    day_nxt = bd7_r - E_FLOOR[e_nxt];

    // Stage 9: month, full year, day of year before leap adjust
    month     = (e8_r < MON_W'(E_WRAP)) ? e8_r - MON_W'(1) : e8_r - MON_W'(13);
    month_idx = month - MON_W'(1);
    late_nxt  = (month >= MON_W'(MONTH_MAR));
    yf_nxt    = late_nxt ? YFW'(c8_r) - YFW'(YEAR_BASE_LATE)
                         : YFW'(c8_r) - YFW'(YEAR_BASE_EARLY);
    doy_nxt   = DAYS_BEFORE[month_idx] + DOY_W'(day8_r);

    // Stage 10: century estimate
    yprod    = (YFW + M4W)'(yf9_r) * (YFW + M4W)'(M4);
    yest_nxt = YFW'(yprod[YFW +: M4W]);

    // Stage 11: correct century, leap test, final day of year
    yrem      = yf10_r - YFW'(cest10_r) * YFW'(DIV_CENT);
    ycarry    = (yrem >= YFW'(DIV_CENT));
    cent      = ycarry ? cest10_r + YFW'(1) : cest10_r;
    cent_zero = (yrem == '0) || (yrem == YFW'(DIV_CENT));
    leap      = (yf10_r[1:0] == 2'b00) && (!cent_zero || (cent[1:0] == 2'b00));
    doy_fin   = (late10_r && leap) ? doy10_r + DOY_W'(1) : doy10_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload: load on advance, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i]) begin
        tod_r[i] <= tod_nxt[i];
      end
    end
    if (adv[0]) begin
      d0_r   <= mjd_day;
      x1_0_r <= x1_nxt;
    end
    if (adv[1]) begin
      d1_r    <= d0_r;
      x1_1_r  <= x1_0_r;
      aest1_r <= aest_nxt;
    end
    if (adv[2]) begin
      d2_r     <= d1_r;
      alpha2_r <= alpha_nxt;
    end
    if (adv[3]) begin
      b3_r   <= b_nxt;
      x2_3_r <= x2_nxt;
    end
    if (adv[4]) begin
      b4_r    <= b3_r;
      x2_4_r  <= x2_3_r;
      cest4_r <= cest_nxt;
    end
    if (adv[5]) begin
      b5_r <= b4_r;
      c5_r <= c_nxt;
    end
    if (adv[6]) begin
      bd6_r <= bd_nxt;
      c6_r  <= c5_r;
    end
    if (adv[7]) begin
      bd7_r   <= bd6_r;
      c7_r    <= c6_r;
      eest7_r <= eest_nxt;
    end
    if (adv[8]) begin
      c8_r   <= c7_r;
      e8_r   <= e_nxt;
      day8_r <= day_nxt;
    end
    if (adv[9]) begin
      yf9_r   <= yf_nxt;
      doy9_r  <= doy_nxt;
      late9_r <= late_nxt;
    end
    if (adv[10]) begin
      yf10_r   <= yf9_r;
      doy10_r  <= doy9_r;
      late10_r <= late9_r;
      cest10_r <= yest_nxt;
    end
    if (adv[11]) begin
      year11_r <= yf10_r[YEAR_W-1:0];
      doy11_r  <= doy_fin;
    end
  end

  assign out_tdata = {1'b0,
                      tod_r[NSTG-1].sec_frac,
                      tod_r[NSTG-1].sec_whole,
                      tod_r[NSTG-1].minute,
                      tod_r[NSTG-1].hour,
                      doy11_r,
                      year11_r};

endmodule

/* dv/mjd_to_calendar_date_tb.sv */
// Self-checking testbench for the MJD to calendar date converter.
`timescale 1ns / 100ps

module mjd_to_calendar_date_tb;
  import mjdcal_pkg::*;

  localparam int unsigned DAY_W      = DAY_BITS_DEF;
  localparam int unsigned IN_W       = ((DAY_W + 32 + 7) / 8) * 8;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT = 30;   // leave margin after the final drain
  localparam int unsigned MAX_REPORTS = 20;

  // One result word, year in the low bits, matching the out_tdata layout.
  typedef struct packed {
    logic [FRAC_W-1:0] sec_fraction;
    logic [SEC_W-1:0]  sec_whole;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [DOY_W-1:0]  day_of_year;
    logic [YEAR_W-1:0] year;
  } date_fields_t;

  // Holds the dates the converter still owes, in acceptance order.
  class date_tracker;
    date_fields_t pending_dates[$];
    int unsigned  errors;

    function new();
      errors = 0;
    endfunction

    // Meeus conversion with the real constants taken as exact ratios.
    function date_fields_t mjd_to_date(logic [DAY_W-1:0] mjd, logic [31:0] frac);
      int unsigned cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      longint unsigned z, alpha, a, b, c, dd, e, dom, month, yr, doy;
      bit [63:0] p, q, s;
      date_fields_t r;
      z     = longint'(mjd) + 2400001;
      alpha = (4 * z - 7468865) / 146097;
      a     = z + 1 + alpha - alpha / 4;
      b     = a + 1524;
      c     = ((10 * b - 1221) * 2) / 7305;
      dd    = (1461 * c) / 4;
      e     = (10000 * (b - dd)) / 306001;
      dom   = b - dd - (306001 * e) / 10000;
      month = (e < 14) ? e - 1 : e - 13;
      yr    = (month > 2) ? c - 4716 : c - 4715;
      doy   = cum_days[month - 1] + dom;
      // March onward in a leap year is one day further into the year
      if (month > 2 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
        doy++;
      // Time of day: truncating fixed-point steps, hours then minutes then seconds
      p = 64'(frac) * 24;
      q = 64'(p[31:0]) * 60;
      s = 64'(q[31:0]) * 60;
      r.year         = yr[YEAR_W-1:0];
      r.day_of_year  = doy[DOY_W-1:0];
      r.hour         = p[32 +: HOUR_W];
      r.minute       = q[32 +: MIN_W];
      r.sec_whole    = s[32 +: SEC_W];
      r.sec_fraction = s[31:0];
      return r;
    endfunction

    function void note_input(logic [IN_W-1:0] word);
      pending_dates.push_back(mjd_to_date(word[DAY_W-1:0], word[DAY_W +: 32]));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      date_fields_t got, want;
      got = word[$bits(date_fields_t)-1:0];
      if (pending_dates.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result word %h", $time, word);
        return;
      end
      want = pending_dates.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch expected y=%0d doy=%0d %0d:%0d:%0d frac=%h, actual y=%0d doy=%0d %0d:%0d:%0d frac=%h",
                   $time, want.year, want.day_of_year, want.hour, want.minute,
                   want.sec_whole, want.sec_fraction, got.year, got.day_of_year,
                   got.hour, got.minute, got.sec_whole, got.sec_fraction);
      end
    endfunction

    function int unsigned pending_count();
      return pending_dates.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  date_tracker tracker = new();

  mjd_to_calendar_date dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #1 clk = ~clk;

  // Track both handshakes at the edge where they happen.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.note_input(in_tdata);
      if (out_tvalid && out_tready)
        tracker.check_result(out_tdata);
    end
  end

  // Receiver: new stall pattern when the phase counter wraps. Mode 0 never stalls,
  // mode 1 stalls at random, mode 2 is ready on ~phase[2], mode 3 on phase[2:0] == 0.
  logic [1:0] ready_mode = 2'd0;
  logic [5:0] ready_phase = 6'd0;

  always @(posedge clk) begin
    ready_phase <= ready_phase + 6'd1;
    if (ready_phase == 6'd0)
      ready_mode <= 2'($urandom_range(0, 3));
    case (ready_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= ~ready_phase[2];
      default: out_tready <= (ready_phase[2:0] == 3'd0);
    endcase
  end

  // Watchdog: end the run when no word moves on either side for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $time, tracker.pending_count());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one word and hold it until the converter takes it.
  task automatic send_word(input logic [DAY_W-1:0] mjd, input logic [31:0] frac);
    in_tdata  <= {{(IN_W - DAY_W - 32){1'b0}}, frac, mjd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
  endtask

  function automatic logic [DAY_W-1:0] pick_mjd();
    // Jan 1 1900, Mar 1 1900, Jan 1 2000, Feb 29 2000, Dec 31 2000,
    // Jan 1 2024, Feb 29 2024, Jan 1 2100
    int unsigned anchors [8] = '{15020, 15079, 51544, 51603, 51909, 60310, 60369, 88069};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DAY_W'($urandom);
      4, 5, 6:    return DAY_W'($urandom_range(40000, 100000));
      default:    return DAY_W'(anchors[$urandom_range(0, 7)] + $urandom_range(0, 4) - 2);
    endcase
  endfunction

  function automatic logic [31:0] pick_fraction();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit          mid_drain_done;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of both fields, the earliest day (Gregorian correction
    // applied from the start), leap and century boundaries, year ends.
    send_word(20'd0,       32'h0000_0000);
    send_word(20'd0,       32'hFFFF_FFFF);
    send_word(20'hFFFFF,   32'h0000_0000);
    send_word(20'hFFFFF,   32'hFFFF_FFFF);
    send_word(20'd1,       32'h0000_0001);
    send_word(20'd15019,   32'h8000_0000);   // Dec 31 1899
    send_word(20'd15020,   32'h5555_5555);   // Jan 1 1900
    send_word(20'd15078,   32'hAAAA_AAAA);   // Feb 28 1900, no leap day
    send_word(20'd15079,   32'h0AAA_AAAB);   // Mar 1 1900
    send_word(20'd51543,   32'hFFFF_FFFE);   // Dec 31 1999
    send_word(20'd51544,   32'h0000_0000);   // Jan 1 2000
    send_word(20'd51602,   32'h4000_0000);   // Feb 28 2000
    send_word(20'd51603,   32'hC000_0000);   // Feb 29 2000
    send_word(20'd51604,   32'h2AAA_AAAA);   // Mar 1 2000
    send_word(20'd51909,   32'hF555_5555);   // Dec 31 2000, day 366
    send_word(20'd51910,   32'h0222_2222);   // Jan 1 2001
    send_word(20'd60369,   32'h1234_5678);   // Feb 29 2024
    send_word(20'd88128,   32'h8765_4321);   // Mar 1 2100, no leap day
    send_word(20'h55555,   32'h5555_5555);
    send_word(20'hAAAAA,   32'hAAAA_AAAA);
    send_word(20'h7FFFF,   32'h7FFF_FFFF);
    send_word(20'h80000,   32'h8000_0001);

    drain_results();

    // Random bursts with random gaps; drain once more halfway through.
    sent = 0;
    mid_drain_done = 1'b0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        send_word(pick_mjd(), pick_fraction());
        sent++;
      end
      if (!mid_drain_done && sent >= RANDOM_WORDS / 2) begin
        drain_results();
        mid_drain_done = 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 8));
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_count() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
